### hdl/tpc_pkg.sv
package tpc_pkg;

   localparam int COORD_BITS   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int DIST_BITS    = 50;
   localparam int DIVISOR_BITS = DIST_BITS + 1;
   localparam int MUL_A_BITS   = (DIST_BITS > COORD_BITS) ? DIST_BITS : COORD_BITS;
   localparam int MUL_B_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;
   localparam int DOT_BITS     = 2 * COORD_BITS + 2;
   localparam int ACC_BITS     = ((PROD_BITS > DOT_BITS) ? PROD_BITS : DOT_BITS) + 1;
   localparam int ITER_BITS    = $clog2(MUL_B_BITS + 1);

   localparam int NUM_AXES  = 3;
   localparam int NUM_COMP  = 6;
   localparam int COMP_BITS = $clog2(NUM_COMP);

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_X  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_Y  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_Z  = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMAL_X = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMAL_Y = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMAL_Z = CSR_INDEX_BITS'(5);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic signed [COORD_BITS-1:0] vel_x;
      logic signed [COORD_BITS-1:0] vel_y;
      logic signed [COORD_BITS-1:0] vel_z;
      logic                         first_point;
      logic                         last_point;
   } tpc_req_type;

   typedef struct packed {
      logic                         found;
      logic signed [COORD_BITS-1:0] cross_pos_x;
      logic signed [COORD_BITS-1:0] cross_pos_y;
      logic signed [COORD_BITS-1:0] cross_pos_z;
      logic signed [COORD_BITS-1:0] cross_vel_x;
      logic signed [COORD_BITS-1:0] cross_vel_y;
      logic signed [COORD_BITS-1:0] cross_vel_z;
   } tpc_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DOT_GO,
      S_DOT_WAIT,
      S_DIST,
      S_DECIDE,
      S_INT_GO,
      S_INT_MUL,
      S_INT_DIV,
      S_OUT
   } tpc_state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_MUL,
      ALU_DIV
   } tpc_alu_state_type;

   typedef enum logic [1:0] {
      OP_ACC,
      OP_MUL,
      OP_DIV
   } tpc_alu_op_type;

   typedef struct packed {
      logic           go;
      tpc_alu_op_type op;
      logic           clear;
      logic           negate;
   } tpc_alu_cmd_type;

endpackage

### hdl/tpc_alu.sv
module tpc_alu (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tpc_pkg::tpc_alu_cmd_type                cmd,
   input  logic [tpc_pkg::MUL_A_BITS-1:0]          mul_a,
   input  logic [tpc_pkg::MUL_B_BITS-1:0]          mul_b,
   input  logic [tpc_pkg::DIVISOR_BITS-1:0]        divisor,
   output logic                                    idle,
   output logic signed [tpc_pkg::ACC_BITS-1:0]     acc,
   output logic [tpc_pkg::MUL_B_BITS-1:0]          quotient
);
   import tpc_pkg::*;

   tpc_alu_state_type          state_ff, state_in;
   logic [ITER_BITS-1:0]       count_ff, count_in;
   logic [MUL_A_BITS-1:0]      mcand_ff, mcand_in;
   logic [MUL_B_BITS-1:0]      shift_ff, shift_in;
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic [DIVISOR_BITS-1:0]    rem_ff, rem_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;

   logic [ACC_BITS-1:0]        add_x, add_y, add_sum;
   logic                       add_sub;
   logic [DIVISOR_BITS:0]      rem_shift;
   logic                       qbit;

   // the one adder that every step goes through
   assign add_sum   = add_x + (add_sub ? ~add_y : add_y) + ACC_BITS'(add_sub);
   assign rem_shift = {rem_ff, shift_ff[MUL_B_BITS-1]};
   assign qbit      = !add_sum[ACC_BITS-1];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ALU_IDLE: begin
            if (cmd.go && cmd.op == OP_MUL) begin
               state_in = ALU_MUL;
            end else if (cmd.go && cmd.op == OP_DIV) begin
               state_in = ALU_DIV;
            end
         end
         ALU_MUL, ALU_DIV: begin
            if (count_ff == ITER_BITS'(1)) begin
               state_in = ALU_IDLE;
            end
         end
         default: state_in = ALU_IDLE;
      endcase
   end

   always_comb begin
      add_x    = '0;
      add_y    = '0;
      add_sub  = 1'b0;
      count_in = count_ff;
      mcand_in = mcand_ff;
      shift_in = shift_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      case (state_ff)
         ALU_IDLE: begin
            add_x   = cmd.clear ? '0 : acc_ff;
            add_y   = ACC_BITS'(prod_ff);
            add_sub = cmd.negate;
            if (cmd.go) begin
               case (cmd.op)
                  OP_ACC: acc_in = $signed(add_sum);
                  OP_MUL: begin
                     mcand_in = mul_a;
                     shift_in = mul_b;
                     prod_in  = '0;
                     count_in = ITER_BITS'(MUL_B_BITS);
                  end
                  OP_DIV: begin
                     // high part of the dividend is already below the divisor
                     rem_in   = DIVISOR_BITS'(prod_ff[PROD_BITS-1:MUL_B_BITS]);
                     shift_in = prod_ff[MUL_B_BITS-1:0];
                     count_in = ITER_BITS'(MUL_B_BITS);
                  end
                  default: acc_in = acc_ff;
               endcase
            end
         end
         ALU_MUL: begin
            // msb first shift and add
            add_x    = ACC_BITS'({prod_ff, 1'b0});
            add_y    = shift_ff[MUL_B_BITS-1] ? ACC_BITS'(mcand_ff) : '0;
            prod_in  = add_sum[PROD_BITS-1:0];
            shift_in = {shift_ff[MUL_B_BITS-2:0], 1'b0};
            count_in = count_ff - ITER_BITS'(1);
         end
         ALU_DIV: begin
            // restoring step, quotient bits enter where dividend bits leave
            add_x    = ACC_BITS'(rem_shift);
            add_y    = ACC_BITS'(divisor);
            add_sub  = 1'b1;
            rem_in   = qbit ? add_sum[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
            shift_in = {shift_ff[MUL_B_BITS-2:0], qbit};
            count_in = count_ff - ITER_BITS'(1);
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      shift_ff <= shift_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      acc_ff   <= acc_in;
   end

   assign idle     = (state_ff == ALU_IDLE);
   assign acc      = acc_ff;
   assign quotient = shift_ff;

`ifndef SYNTHESIS
   a_go_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.go |-> state_ff == ALU_IDLE)
      else $error("command issued to a busy unit");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ALU_DIV |-> rem_ff < divisor)
      else $error("partial remainder not below divisor");

   a_mul_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.go && cmd.op == OP_MUL |=> state_ff == ALU_MUL)
      else $error("multiply did not start");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      state_ff != ALU_IDLE |-> count_ff != '0)
      else $error("iteration count empty while busy");
`endif

endmodule

### hdl/trajectory_plane_crossing.sv
// Plane crossing detector for a scanned trajectory. Each accepted point takes its distance to
// the configured plane as a three-term dot product on one shared shift-and-add unit (three
// 33-step multiplies plus one accumulate each, then saturate and decide). A point that closes
// a crossing adds the interpolation: for each of the six components a 33-step multiply and a
// 33-step restoring divide on the same unit, then the result register is loaded. Points
// ignored after a crossing do not use the unit. The result register holds a finished result
// while the next point is already taken; the block stalls its input whenever it is not idle,
// also while it waits for the result register to be free.
module trajectory_plane_crossing (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tpc_pkg::tpc_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tpc_pkg::tpc_rsp_type                 rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [tpc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tpc_pkg::COORD_BITS-1:0]       csr_wdata
);
   import tpc_pkg::*;

   localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
   localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

   function automatic logic [MUL_B_BITS-1:0] mag_coord(input logic signed [MUL_B_BITS-1:0] v);
      return v[MUL_B_BITS-1] ? MUL_B_BITS'(-v) : MUL_B_BITS'(v);
   endfunction

   function automatic logic [DIST_BITS-1:0] mag_dist(input logic signed [DIST_BITS-1:0] v);
      return v[DIST_BITS-1] ? DIST_BITS'(-v) : DIST_BITS'(v);
   endfunction

   tpc_state_type              state_ff, state_in;
   logic [COMP_BITS-1:0]       comp_ff, comp_in;
   logic signed [COORD_BITS-1:0] plane_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] plane_in [NUM_AXES];
   logic signed [COORD_BITS-1:0] normal_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] normal_in [NUM_AXES];
   logic signed [COORD_BITS-1:0] pt_ff [NUM_COMP];
   logic signed [COORD_BITS-1:0] pt_in [NUM_COMP];
   logic signed [COORD_BITS-1:0] prev_ff [NUM_COMP];
   logic signed [COORD_BITS-1:0] prev_in [NUM_COMP];
   logic signed [COORD_BITS-1:0] res_ff [NUM_COMP];
   logic signed [COORD_BITS-1:0] res_in [NUM_COMP];
   logic                       last_ff, last_in;
   logic                       hp_ff, hp_in;
   logic                       cd_ff, cd_in;
   logic                       found_ff, found_in;
   logic signed [DIST_BITS-1:0] dist_ff, dist_in;
   logic signed [DIST_BITS-1:0] prev_dist_ff, prev_dist_in;
   logic [DIST_BITS-1:0]       a_ff, a_in;
   logic [DIVISOR_BITS-1:0]    d_ff, d_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   tpc_rsp_type                rsp_data_ff, rsp_data_in;

   tpc_alu_cmd_type            alu_cmd;
   logic [MUL_A_BITS-1:0]      mul_a;
   logic [MUL_B_BITS-1:0]      mul_b;
   logic                       alu_idle;
   logic signed [ACC_BITS-1:0] alu_acc;
   logic [MUL_B_BITS-1:0]      alu_quo;

   logic                       req_fire, rsp_free, skip_point;
   logic signed [MUL_B_BITS-1:0] dot_diff, normal_ext, delta, prev_ext, interp;
   logic [MUL_B_BITS-1:0]      dot_mag, normal_mag, delta_mag;
   logic                       dot_neg;
   logic signed [ACC_BITS-1:0] acc_shift;
   logic [ACC_BITS-DIST_BITS:0] acc_top;
   logic signed [DIST_BITS-1:0] dist_sat;
   logic                       cur_pos, prev_pos, crossing;
   logic [DIST_BITS-1:0]       cur_mag, prev_mag;

   tpc_alu u_alu (
      .clock    (clock),
      .reset    (reset),
      .cmd      (alu_cmd),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .divisor  (d_ff),
      .idle     (alu_idle),
      .acc      (alu_acc),
      .quotient (alu_quo)
   );

   assign req_fire   = req_valid && (state_ff == S_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   // once a crossing is out, the rest of the trajectory is dropped
   assign skip_point = cd_ff && !req_data.first_point;

   // dot product term: normal[k] * (plane[k] - pos[k])
   assign dot_diff   = MUL_B_BITS'(plane_ff[comp_ff[1:0]]) - MUL_B_BITS'(pt_ff[comp_ff]);
   assign normal_ext = MUL_B_BITS'(normal_ff[comp_ff[1:0]]);
   assign dot_mag    = mag_coord(dot_diff);
   assign normal_mag = mag_coord(normal_ext);
   assign dot_neg    = dot_diff[MUL_B_BITS-1] ^ normal_ext[MUL_B_BITS-1];

   // floor shift back to the fraction format, then saturate
   assign acc_shift = alu_acc >>> FRAC_BITS;
   assign acc_top   = acc_shift[ACC_BITS-1:DIST_BITS-1];
   assign dist_sat  = (&acc_top || !(|acc_top)) ? acc_shift[DIST_BITS-1:0]
                    : (acc_shift[ACC_BITS-1] ? DIST_MIN : DIST_MAX);

   // zero counts as negative
   assign cur_pos  = !dist_ff[DIST_BITS-1] && (|dist_ff);
   assign prev_pos = !prev_dist_ff[DIST_BITS-1] && (|prev_dist_ff);
   assign crossing = hp_ff && (cur_pos != prev_pos);
   assign cur_mag  = mag_dist(dist_ff);
   assign prev_mag = mag_dist(prev_dist_ff);

   assign delta     = MUL_B_BITS'(pt_ff[comp_ff]) - MUL_B_BITS'(prev_ff[comp_ff]);
   assign delta_mag = mag_coord(delta);
   assign prev_ext  = MUL_B_BITS'(prev_ff[comp_ff]);
   assign interp    = delta[MUL_B_BITS-1] ? prev_ext - $signed(alu_quo)
                                          : prev_ext + $signed(alu_quo);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && !skip_point) begin
               state_in = S_DOT_GO;
            end
         end
         S_DOT_GO: state_in = S_DOT_WAIT;
         S_DOT_WAIT: begin
            if (alu_idle) begin
               state_in = (comp_ff == COMP_BITS'(NUM_AXES - 1)) ? S_DIST : S_DOT_GO;
            end
         end
         S_DIST: state_in = S_DECIDE;
         S_DECIDE: begin
            if (crossing) begin
               state_in = S_INT_GO;
            end else if (last_ff) begin
               state_in = S_OUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_INT_GO: state_in = S_INT_MUL;
         S_INT_MUL: begin
            if (alu_idle) begin
               state_in = S_INT_DIV;
            end
         end
         S_INT_DIV: begin
            if (alu_idle) begin
               state_in = (comp_ff == COMP_BITS'(NUM_COMP - 1)) ? S_OUT : S_INT_GO;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      plane_in  = plane_ff;
      normal_in = normal_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PLANE_X:  plane_in[0]  = csr_wdata;
            CSR_PLANE_Y:  plane_in[1]  = csr_wdata;
            CSR_PLANE_Z:  plane_in[2]  = csr_wdata;
            CSR_NORMAL_X: normal_in[0] = csr_wdata;
            CSR_NORMAL_Y: normal_in[1] = csr_wdata;
            CSR_NORMAL_Z: normal_in[2] = csr_wdata;
            default: plane_in = plane_ff;
         endcase
      end
   end

   always_comb begin
      comp_in      = comp_ff;
      pt_in        = pt_ff;
      prev_in      = prev_ff;
      res_in       = res_ff;
      last_in      = last_ff;
      hp_in        = hp_ff;
      cd_in        = cd_ff;
      found_in     = found_ff;
      dist_in      = dist_ff;
      prev_dist_in = prev_dist_ff;
      a_in         = a_ff;
      d_in         = d_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      alu_cmd      = '0;
      alu_cmd.op   = OP_ACC;
      mul_a        = '0;
      mul_b        = '0;
      req_stall    = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pt_in[0] = req_data.pos_x;
               pt_in[1] = req_data.pos_y;
               pt_in[2] = req_data.pos_z;
               pt_in[3] = req_data.vel_x;
               pt_in[4] = req_data.vel_y;
               pt_in[5] = req_data.vel_z;
               last_in  = req_data.last_point;
               comp_in  = '0;
               if (req_data.first_point || (skip_point && req_data.last_point)) begin
                  hp_in = 1'b0;
                  cd_in = 1'b0;
               end
            end
         end
         S_DOT_GO: begin
            alu_cmd.go = 1'b1;
            alu_cmd.op = OP_MUL;
            mul_a      = MUL_A_BITS'(normal_mag);
            mul_b      = dot_mag;
         end
         S_DOT_WAIT: begin
            if (alu_idle) begin
               alu_cmd.go     = 1'b1;
               alu_cmd.op     = OP_ACC;
               alu_cmd.clear  = (comp_ff == '0);
               alu_cmd.negate = dot_neg;
               comp_in        = comp_ff + COMP_BITS'(1);
            end
         end
         S_DIST: dist_in = dist_sat;
         S_DECIDE: begin
            comp_in = '0;
            if (crossing) begin
               cd_in    = 1'b1;
               found_in = 1'b1;
               a_in     = prev_mag;
               // signs differ, so |dc - dp| is the sum of the magnitudes
               d_in     = DIVISOR_BITS'(prev_mag) + DIVISOR_BITS'(cur_mag);
            end else begin
               prev_in      = pt_ff;
               prev_dist_in = dist_ff;
               hp_in        = 1'b1;
               found_in     = 1'b0;
            end
            if (last_ff) begin
               hp_in = 1'b0;
               cd_in = 1'b0;
            end
         end
         S_INT_GO: begin
            alu_cmd.go = 1'b1;
            alu_cmd.op = OP_MUL;
            mul_a      = MUL_A_BITS'(a_ff);
            mul_b      = delta_mag;
         end
         S_INT_MUL: begin
            if (alu_idle) begin
               alu_cmd.go = 1'b1;
               alu_cmd.op = OP_DIV;
            end
         end
         S_INT_DIV: begin
            if (alu_idle) begin
               res_in[comp_ff] = interp[COORD_BITS-1:0];
               comp_in         = comp_ff + COMP_BITS'(1);
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (found_ff) begin
                  rsp_data_in.found       = 1'b1;
                  rsp_data_in.cross_pos_x = res_ff[0];
                  rsp_data_in.cross_pos_y = res_ff[1];
                  rsp_data_in.cross_pos_z = res_ff[2];
                  rsp_data_in.cross_vel_x = res_ff[3];
                  rsp_data_in.cross_vel_y = res_ff[4];
                  rsp_data_in.cross_vel_z = res_ff[5];
               end
            end
         end
         default: comp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         comp_ff      <= '0;
         hp_ff        <= 1'b0;
         cd_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         plane_ff     <= '{default: '0};
         normal_ff    <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         hp_ff        <= hp_in;
         cd_ff        <= cd_in;
         rsp_valid_ff <= rsp_valid_in;
         plane_ff     <= plane_in;
         normal_ff    <= normal_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff        <= pt_in;
      prev_ff      <= prev_in;
      res_ff       <= res_in;
      last_ff      <= last_in;
      found_ff     <= found_in;
      dist_ff      <= dist_in;
      prev_dist_ff <= prev_dist_in;
      a_ff         <= a_in;
      d_ff         <= d_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_done_has_prev: assert property (@(posedge clock) disable iff (reset)
      cd_ff |-> hp_ff)
      else $error("crossing marked without a reference point");

   a_divisor_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INT_GO || state_ff == S_INT_MUL || state_ff == S_INT_DIV)
      |-> d_ff != '0 && DIVISOR_BITS'(a_ff) <= d_ff)
      else $error("interpolation weight out of range");

   a_miss_on_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && rsp_free && !found_ff |-> last_ff)
      else $error("no-crossing result for a point that does not end the trajectory");

   a_unit_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> alu_idle)
      else $error("arithmetic unit busy while waiting for a point");
`endif

endmodule
